// File: rtl/core/tcmc_pkg.sv
// Shared types and constants for the tau candidate match-and-count block.
// No dependencies.
`default_nettype none
package tcmc_pkg;

    localparam int CandWidth   = 27;
    localparam int EtWidth     = 12;
    localparam int FactorWidth = 11;

    localparam logic [1:0] MODE_ISO    = 2'd0;
    localparam logic [1:0] MODE_ENERGY = 2'd1;
    localparam logic [1:0] MODE_THRESH = 2'd2;
    localparam logic [1:0] MODE_SPARE  = 2'd3;

    localparam logic [1:0] CFG_LOOSE  = 2'd0;
    localparam logic [1:0] CFG_MEDIUM = 2'd1;
    localparam logic [1:0] CFG_TIGHT  = 2'd2;
    localparam logic [1:0] CFG_LEVEL  = 2'd3;

    localparam logic [1:0] LEVEL_LAST = 2'd2;

    typedef struct packed {
        logic [11:0]       et;
        logic signed [7:0] eta;
        logic [6:0]        phi;
    } cand_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_E_READ,
        ST_E_WAIT,
        ST_I_READ,
        ST_I_CHECK,
        ST_SCORE,
        ST_EVAL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic count_init;
        logic e_read;
        logic tbl_read;
        logic i_read;
        logic j_inc;
        logic match_take;
        logic score_step;
        logic eval;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic i_done;
        logic j_done;
        logic tower_hit;
        logic k_last;
    } stat_t;

endpackage
`default_nettype wire

// File: rtl/core/tcmc_ctrl.sv
// Sequencer for loading and the matching pass.
// Depends on tcmc_pkg.
`default_nettype none
module tcmc_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic           last_item,
    input  wire tcmc_pkg::stat_t stat,
    output tcmc_pkg::cmd_t      cmd,
    output logic                busy
);

    tcmc_pkg::state_t state_reg;
    tcmc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcmc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        busy = 1'b1;
        case (state_reg)
            tcmc_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (last_item)
                    begin
                        cmd.count_init = 1'b1;
                        state_next = tcmc_pkg::ST_E_READ;
                    end
                end
            end
            tcmc_pkg::ST_E_READ:
            begin
                if (stat.i_done)
                begin
                    state_next = tcmc_pkg::ST_DONE;
                end
                else
                begin
                    cmd.e_read = 1'b1;
                    state_next = tcmc_pkg::ST_E_WAIT;
                end
            end
            tcmc_pkg::ST_E_WAIT:
            begin
                cmd.tbl_read = 1'b1;
                state_next = tcmc_pkg::ST_I_READ;
            end
            tcmc_pkg::ST_I_READ:
            begin
                if (stat.j_done)
                begin
                    state_next = tcmc_pkg::ST_EVAL;
                end
                else
                begin
                    cmd.i_read = 1'b1;
                    state_next = tcmc_pkg::ST_I_CHECK;
                end
            end
            tcmc_pkg::ST_I_CHECK:
            begin
                if (stat.tower_hit)
                begin
                    cmd.match_take = 1'b1;
                    state_next = tcmc_pkg::ST_SCORE;
                end
                else
                begin
                    cmd.j_inc = 1'b1;
                    state_next = tcmc_pkg::ST_I_READ;
                end
            end
            tcmc_pkg::ST_SCORE:
            begin
                cmd.score_step = 1'b1;
                if (stat.k_last)
                begin
                    state_next = tcmc_pkg::ST_EVAL;
                end
            end
            tcmc_pkg::ST_EVAL:
            begin
                cmd.eval = 1'b1;
                state_next = tcmc_pkg::ST_E_READ;
            end
            tcmc_pkg::ST_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = tcmc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tcmc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/core/tcmc_dp.sv
// Datapath: candidate stores, threshold table, configuration, scoring and count.
// Depends on tcmc_pkg.
`default_nettype none
module tcmc_dp #(
    parameter int ENERGY_DEPTH      = 16,
    parameter int ISO_DEPTH         = 16,
    parameter int THRESHOLD_ENTRIES = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire tcmc_pkg::cmd_t    cmd,
    output tcmc_pkg::stat_t        stat,
    input  wire logic              cfg_valid,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [10:0]       cfg_data,
    input  wire logic [1:0]        mode,
    input  wire logic [11:0]       energy,
    input  wire logic [11:0]       iso_energy,
    input  wire logic signed [7:0] eta_code,
    input  wire logic [6:0]        phi_code,
    input  wire logic [5:0]        table_index,
    output logic                   done,
    output logic [4:0]             multiplicity,
    output logic                   overflow
);

    localparam int EW = (ENERGY_DEPTH > 1) ? $clog2(ENERGY_DEPTH) : 1;
    localparam int IW = (ISO_DEPTH > 1) ? $clog2(ISO_DEPTH) : 1;
    localparam int EF = $clog2(ENERGY_DEPTH + 1);
    localparam int IF = $clog2(ISO_DEPTH + 1);
    localparam int TW = $clog2(THRESHOLD_ENTRIES);

    tcmc_pkg::cand_t energy_mem [ENERGY_DEPTH];
    tcmc_pkg::cand_t iso_mem [ISO_DEPTH];
    logic [11:0]     thr_mem [THRESHOLD_ENTRIES];

    logic [10:0] loose_reg, medium_reg, tight_reg;
    logic [1:0]  level_reg;

    logic [EF-1:0] efill_reg;
    logic [IF-1:0] ifill_reg;
    logic          dropped_reg;
    logic [EF-1:0] i_reg;
    logic [IF-1:0] j_reg;
    logic [1:0]    k_reg;
    logic [1:0]    score_reg;
    logic          matched_reg;
    logic          thr_ok_reg;
    logic [11:0]   thr_q_reg;
    logic [11:0]   iso_et_reg;
    logic [4:0]    count_reg;
    logic [4:0]    count_next;
    logic          done_reg;
    logic [4:0]    mult_reg;
    logic          ovf_reg;

    tcmc_pkg::cand_t e_q_reg;
    tcmc_pkg::cand_t i_q_reg;
    tcmc_pkg::cand_t in_cand;

    logic signed [7:0] idx;
    logic [10:0]       fac;
    logic [22:0]       lhs;
    logic [22:0]       rhs;
    logic              pass;

    assign in_cand.et  = (mode == tcmc_pkg::MODE_ISO) ? iso_energy : energy;
    assign in_cand.eta = eta_code;
    assign in_cand.phi = phi_code;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loose_reg  <= '0;
            medium_reg <= '0;
            tight_reg  <= '0;
            level_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tcmc_pkg::CFG_LOOSE:  loose_reg  <= cfg_data;
                tcmc_pkg::CFG_MEDIUM: medium_reg <= cfg_data;
                tcmc_pkg::CFG_TIGHT:  tight_reg  <= cfg_data;
                tcmc_pkg::CFG_LEVEL:  level_reg  <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Stores and table
    always_ff @(posedge clk)
    begin
        if (cmd.load && mode == tcmc_pkg::MODE_ENERGY && efill_reg != EF'(ENERGY_DEPTH))
        begin
            energy_mem[efill_reg[EW-1:0]] <= in_cand;
        end
        if (cmd.load && mode == tcmc_pkg::MODE_ISO && ifill_reg != IF'(ISO_DEPTH))
        begin
            iso_mem[ifill_reg[IW-1:0]] <= in_cand;
        end
        if (cmd.load && mode == tcmc_pkg::MODE_THRESH
            && {1'b0, table_index} < 7'(THRESHOLD_ENTRIES))
        begin
            thr_mem[table_index[TW-1:0]] <= energy;
        end
        if (cmd.e_read)
        begin
            e_q_reg <= energy_mem[i_reg[EW-1:0]];
        end
        if (cmd.i_read)
        begin
            i_q_reg <= iso_mem[j_reg[IW-1:0]];
        end
        if (cmd.tbl_read)
        begin
            thr_q_reg <= thr_mem[idx[TW-1:0]];
        end
    end

    assign idx = {{2{e_q_reg.eta[7]}}, e_q_reg.eta[7:2]} + 8'sd25;

    always_comb
    begin
        case (k_reg)
            2'd0:    fac = loose_reg;
            2'd1:    fac = medium_reg;
            default: fac = tight_reg;
        endcase
    end

    assign lhs = {1'b0, iso_et_reg, 10'b0};
    assign rhs = 23'(e_q_reg.et) * 23'(fac);

    assign pass = (!matched_reg || score_reg >= level_reg) && thr_ok_reg
                  && (e_q_reg.et > thr_q_reg);
    assign count_next = (pass && count_reg != 5'd31) ? count_reg + 5'd1 : count_reg;

    assign stat.i_done    = (i_reg == efill_reg);
    assign stat.j_done    = (j_reg == ifill_reg);
    assign stat.tower_hit = (i_q_reg.eta[7:2] == e_q_reg.eta[7:2])
                            && (i_q_reg.phi[6:1] == e_q_reg.phi[6:1]);
    assign stat.k_last    = (k_reg == tcmc_pkg::LEVEL_LAST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            efill_reg   <= '0;
            ifill_reg   <= '0;
            dropped_reg <= 1'b0;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            score_reg   <= '0;
            matched_reg <= 1'b0;
            thr_ok_reg  <= 1'b0;
            count_reg   <= '0;
            done_reg    <= 1'b0;
            mult_reg    <= '0;
            ovf_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cmd.load && mode == tcmc_pkg::MODE_ENERGY)
            begin
                if (efill_reg != EF'(ENERGY_DEPTH))
                    efill_reg <= efill_reg + EF'(1);
                else
                    dropped_reg <= 1'b1;
            end
            if (cmd.load && mode == tcmc_pkg::MODE_ISO)
            begin
                if (ifill_reg != IF'(ISO_DEPTH))
                    ifill_reg <= ifill_reg + IF'(1);
                else
                    dropped_reg <= 1'b1;
            end
            if (cmd.count_init)
            begin
                i_reg     <= '0;
                count_reg <= '0;
            end
            if (cmd.tbl_read)
            begin
                j_reg       <= '0;
                matched_reg <= 1'b0;
                thr_ok_reg  <= !idx[7] && (idx[6:0] < 7'(THRESHOLD_ENTRIES));
            end
            if (cmd.j_inc)
            begin
                j_reg <= j_reg + IF'(1);
            end
            if (cmd.match_take)
            begin
                matched_reg <= 1'b1;
                score_reg   <= '0;
                k_reg       <= '0;
                iso_et_reg  <= i_q_reg.et;
            end
            if (cmd.score_step)
            begin
                if (lhs < rhs)
                    score_reg <= k_reg + 2'd1;
                k_reg <= k_reg + 2'd1;
            end
            if (cmd.eval)
            begin
                count_reg <= count_next;
                i_reg     <= i_reg + EF'(1);
            end
            if (cmd.finish)
            begin
                mult_reg    <= count_reg;
                ovf_reg     <= dropped_reg;
                efill_reg   <= '0;
                ifill_reg   <= '0;
                dropped_reg <= 1'b0;
                i_reg       <= '0;
            end
        end
    end

    assign done         = done_reg;
    assign multiplicity = mult_reg;
    assign overflow     = ovf_reg;

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("result strobe longer than one cycle");
    a_efill_range: assert property (@(posedge clk) disable iff (!rst_n)
        efill_reg <= EF'(ENERGY_DEPTH)) else $error("energy fill beyond depth");
    a_clear_after: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (efill_reg == '0 && ifill_reg == '0 && !dropped_reg))
        else $error("event state not cleared");
    a_i_bound: assert property (@(posedge clk) disable iff (!rst_n)
        i_reg <= efill_reg || cmd.load) else $error("candidate index past fill");

endmodule
`default_nettype wire

// File: rtl/core/tau_candidate_match_count.sv
// Top level of the tau candidate match-and-count block.
// Depends on tcmc_pkg, tcmc_ctrl and tcmc_dp.
//
// Usage:
//   Items are taken one per cycle while busy is low: start high with the
//   item fields. mode selects an isolation candidate, an energy candidate or
//   a threshold table write. An item with last_item high closes the event.
//   After the last item, busy stays high for the matching pass: each stored
//   energy candidate and its threshold entry are read, isolation candidates
//   are scanned for one in the same tower, and a match is scored against the
//   three factors. Then done pulses for one cycle with multiplicity and
//   overflow, the stores empty, and busy drops in that same cycle.
//   The threshold table is kept between events.
//   Configuration: cfg_valid with cfg_index and cfg_data; cfg_ready is
//   always high. Write only while busy is low and no item is pending.
//   Reset clears stores fills, drop flag and registers; table contents are
//   undefined until written. The receiver of done cannot stall.
`default_nettype none
module tau_candidate_match_count #(
    parameter int ENERGY_DEPTH      = 16,
    parameter int ISO_DEPTH         = 16,
    parameter int THRESHOLD_ENTRIES = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [1:0]        mode,
    input  wire logic [11:0]       energy,
    input  wire logic [11:0]       iso_energy,
    input  wire logic signed [7:0] eta_code,
    input  wire logic [6:0]        phi_code,
    input  wire logic [5:0]        table_index,
    input  wire logic              last_item,
    output logic                   done,
    output logic [4:0]             multiplicity,
    output logic                   overflow,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [10:0]       cfg_data
);

    tcmc_pkg::cmd_t  cmd;
    tcmc_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    tcmc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .last_item (last_item),
        .stat      (stat),
        .cmd       (cmd),
        .busy      (busy)
    );

    tcmc_dp #(
        .ENERGY_DEPTH      (ENERGY_DEPTH),
        .ISO_DEPTH         (ISO_DEPTH),
        .THRESHOLD_ENTRIES (THRESHOLD_ENTRIES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mode         (mode),
        .energy       (energy),
        .iso_energy   (iso_energy),
        .eta_code     (eta_code),
        .phi_code     (phi_code),
        .table_index  (table_index),
        .done         (done),
        .multiplicity (multiplicity),
        .overflow     (overflow)
    );

endmodule
`default_nettype wire

// File: test/tb.sv
// Testbench for tau_candidate_match_count: drives events of candidates,
// predicts the accepted count per event and checks every done transfer.
// Depends on tcmc_pkg and the block's RTL.
`timescale 1ns / 1ps
module tb;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [1:0]        mode = tcmc_pkg::MODE_ISO;
    logic [11:0]       energy = '0;
    logic [11:0]       iso_energy = '0;
    logic signed [7:0] eta_code = '0;
    logic [6:0]        phi_code = '0;
    logic [5:0]        table_index = '0;
    logic              last_item = 1'b0;
    logic              done;
    logic [4:0]        multiplicity;
    logic              overflow;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [1:0]        cfg_index = tcmc_pkg::CFG_LOOSE;
    logic [10:0]       cfg_data = '0;

    localparam int EDEPTH = 16;
    localparam int IDEPTH = 16;

    typedef struct {
        logic [4:0] count;
        logic       ovf;
    } tally_t;

    tau_candidate_match_count uut (.*);

    always #5 clk = ~clk;

    tcmc_pkg::cand_t en_cands[$];
    tcmc_pkg::cand_t iso_cands[$];
    logic         lost;
    logic [11:0]  thresh[64];
    logic [10:0]  f_loose, f_medium, f_tight;
    logic [1:0]   req_level;
    tally_t       pending_tallies[$];
    int           errors = 0;
    int           quiet = 0;

    function automatic int tower_of(logic signed [7:0] eta);
        return int'(eta) >>> 2;
    endfunction

    function automatic int score_of(logic [11:0] iso, logic [11:0] et);
        logic [31:0] lhs;
        int s;
        lhs = {20'd0, iso} * 32'd1024;
        s = 0;
        if (lhs < et * f_loose) s = 1;
        if (lhs < et * f_medium) s = 2;
        if (lhs < et * f_tight) s = 3;
        return s;
    endfunction

    function automatic tally_t close_event();
        tally_t t;
        int n;
        int idx;
        bit ok;
        n = 0;
        foreach (en_cands[i]) begin
            ok = 1;
            foreach (iso_cands[j]) begin
                if (tower_of(iso_cands[j].eta) == tower_of(en_cands[i].eta)
                    && iso_cands[j].phi[6:1] == en_cands[i].phi[6:1]) begin
                    ok = score_of(iso_cands[j].et, en_cands[i].et) >= req_level;
                    break;
                end
            end
            idx = tower_of(en_cands[i].eta) + 25;
            if (idx < 0 || idx >= 64) ok = 0;
            else if (!(en_cands[i].et > thresh[idx])) ok = 0;
            if (ok) n++;
        end
        t.count = (n > 31) ? 5'd31 : 5'(n);
        t.ovf = lost;
        en_cands.delete();
        iso_cands.delete();
        lost = 0;
        return t;
    endfunction

    task automatic idle_gap();
        if (quiet == 0) begin
            while ($urandom_range(99) < 17) begin
                start <= 1'b0;
                @(posedge clk);
            end
        end
    endtask

    task automatic send_item(logic [1:0] m, logic [11:0] e, logic [11:0] iso,
                             logic signed [7:0] eta, logic [6:0] phi,
                             logic [5:0] ti, logic last);
        tcmc_pkg::cand_t c;
        idle_gap();
        start <= 1'b1;
        mode <= m;
        energy <= e;
        iso_energy <= iso;
        eta_code <= eta;
        phi_code <= phi;
        table_index <= ti;
        last_item <= last;
        @(posedge clk);
        while (busy) @(posedge clk);
        c.et = (m == tcmc_pkg::MODE_ISO) ? iso : e;
        c.eta = eta;
        c.phi = phi;
        if (m == tcmc_pkg::MODE_ISO) begin
            if (iso_cands.size() < IDEPTH) iso_cands.push_back(c);
            else lost = 1;
        end else if (m == tcmc_pkg::MODE_ENERGY) begin
            if (en_cands.size() < EDEPTH) en_cands.push_back(c);
            else lost = 1;
        end else if (m == tcmc_pkg::MODE_THRESH) begin
            thresh[ti] = e;
        end
        if (last) pending_tallies.push_back(close_event());
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_tallies.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [10:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            tcmc_pkg::CFG_LOOSE:  f_loose = val;
            tcmc_pkg::CFG_MEDIUM: f_medium = val;
            tcmc_pkg::CFG_TIGHT:  f_tight = val;
            default:              req_level = val[1:0];
        endcase
    endtask

    task automatic set_regs(logic [10:0] l, logic [10:0] m, logic [10:0] t,
                            logic [1:0] lvl);
        drain();
        write_reg(tcmc_pkg::CFG_LOOSE, l);
        write_reg(tcmc_pkg::CFG_MEDIUM, m);
        write_reg(tcmc_pkg::CFG_TIGHT, t);
        write_reg(tcmc_pkg::CFG_LEVEL, lvl);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [7:0] rand_eta();
        if ($urandom_range(9) == 0) return 8'($urandom);
        return 8'($signed($urandom_range(199)) - 100);
    endfunction

    task automatic fill_table();
        for (int i = 0; i < 64; i++)
            send_item(tcmc_pkg::MODE_THRESH, 12'($urandom_range(300)), 12'($urandom),
                      rand_eta(), 7'($urandom), 6'(i), 1'b0);
    endtask

    task automatic test_directed();
        send_item(tcmc_pkg::MODE_ENERGY, 12'd4095, 12'd0, -8'sd100, 7'd0, 6'd0, 1'b0);
        send_item(tcmc_pkg::MODE_ISO, 12'd0, 12'd4095, -8'sd100, 7'd1, 6'd63, 1'b0);
        send_item(tcmc_pkg::MODE_ENERGY, 12'd0, 12'd0, 8'sd99, 7'd127, 6'd0, 1'b0);
        send_item(tcmc_pkg::MODE_ISO, 12'd4095, 12'd0, 8'sd99, 7'd126, 6'd0, 1'b0);
        send_item(tcmc_pkg::MODE_ENERGY, 12'd2000, 12'd0, -8'sd128, 7'd5, 6'd0, 1'b0);
        send_item(tcmc_pkg::MODE_ENERGY, 12'd2000, 12'd0, 8'sd127, 7'd5, 6'd0, 1'b0);
        send_item(tcmc_pkg::MODE_THRESH, 12'd4095, 12'd0, 8'sd0, 7'd0, 6'd63, 1'b0);
        send_item(tcmc_pkg::MODE_SPARE, 12'd4095, 12'd4095, 8'sd0, 7'd0, 6'd0, 1'b1);
        for (int i = 0; i < 18; i++)
            send_item((i % 2) ? tcmc_pkg::MODE_ISO : tcmc_pkg::MODE_ENERGY, 12'd500,
                      12'd10, 8'sd4, 7'd8, 6'd0, 1'b0);
        send_item(tcmc_pkg::MODE_ENERGY, 12'd500, 12'd10, 8'sd4, 7'd8, 6'd0, 1'b1);
        send_item(tcmc_pkg::MODE_THRESH, 12'd7, 12'd0, 8'sd0, 7'd0, 6'd25, 1'b1);
    endtask

    task automatic test_random_events(int n_items, int max_cands);
        int sent;
        int len;
        logic [1:0] m;
        sent = 0;
        while (sent < n_items) begin
            len = $urandom_range(max_cands);
            for (int k = 0; k <= len; k++) begin
                case ($urandom_range(19))
                    0: m = tcmc_pkg::MODE_THRESH;
                    1: m = tcmc_pkg::MODE_SPARE;
                    2, 3, 4, 5, 6, 7, 8: m = tcmc_pkg::MODE_ISO;
                    default: m = tcmc_pkg::MODE_ENERGY;
                endcase
                send_item(m, ($urandom_range(3) == 0) ? 12'($urandom)
                                                      : 12'($urandom_range(400)),
                          ($urandom_range(1)) ? 12'($urandom) : 12'($urandom_range(40)),
                          ($urandom_range(1)) ? 8'($signed($urandom_range(15)) - 8)
                                              : rand_eta(),
                          ($urandom_range(1)) ? 7'($urandom_range(7)) : 7'($urandom),
                          6'($urandom), k == len);
                sent++;
            end
        end
    endtask

    task automatic test_quiet_burst();
        quiet = 1;
        test_random_events(150, 10);
        quiet = 0;
    endtask

    always @(posedge clk) begin
        if (done) begin
            if (pending_tallies.size() == 0) begin
                $display("%0t: unexpected result mult=%0d ovf=%0b", $time,
                         multiplicity, overflow);
                errors++;
            end else begin
                if (multiplicity !== pending_tallies[0].count) begin
                    $display("%0t: multiplicity expected %0d actual %0d", $time,
                             pending_tallies[0].count, multiplicity);
                    errors++;
                end
                if (overflow !== pending_tallies[0].ovf) begin
                    $display("%0t: overflow expected %0b actual %0b", $time,
                             pending_tallies[0].ovf, overflow);
                    errors++;
                end
                void'(pending_tallies.pop_front());
            end
        end
    end

    initial begin
        lost = 0;
        f_loose = 0;
        f_medium = 0;
        f_tight = 0;
        req_level = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        fill_table();
        test_directed();
        set_regs(11'd2047, 11'd2047, 11'd2047, 2'd3);
        test_directed();
        set_regs(11'd100, 11'd300, 11'd900, 2'd1);
        test_random_events(300, 20);
        set_regs(11'($urandom), 11'($urandom), 11'($urandom), 2'd2);
        test_quiet_burst();
        set_regs(11'd200, 11'd600, 11'd1500, 2'd3);
        test_random_events(300, 8);
        drain();
        fill_table();
        set_regs(11'd0, 11'd1024, 11'd2047, 2'd0);
        test_random_events(350, 24);
        drain();
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
